### hw/rtl/rotation_gram_schmidt_orthonormalize_top_assert.svh
// Assertion macros shared by the orthonormalization RTL files.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef ROTATION_GRAM_SCHMIDT_ORTHONORMALIZE_TOP_ASSERT_SVH
`define ROTATION_GRAM_SCHMIDT_ORTHONORMALIZE_TOP_ASSERT_SVH
`define RGSO_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define RGSO_ASSERT_HOLDS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`endif

### hw/rtl/rgso_pkg.sv
// Package for the 3x3 Gram-Schmidt orthonormalization block.
// Holds the transaction structs, fixed datapath widths and the sideband type.
`timescale 1ns / 1ps
package rgso_pkg;

  localparam int A_W = 16;
  localparam int OUT_W = 16;
  localparam int PROD_W = 32;
  localparam int N_W = 33;
  localparam int S1_W = 32;
  localparam int D12_W = 33;
  localparam int WIDE_P_W = 49;
  localparam int DET_W = 51;
  localparam int B2_W = 50;
  localparam int NORM_W = 30;
  localparam int Q_W = 62;
  localparam int ROOT_W = 31;
  localparam int ROOT_STEPS = Q_W / 2;

  typedef struct packed {
    logic signed [A_W-1:0] col0_x;
    logic signed [A_W-1:0] col0_y;
    logic signed [A_W-1:0] col0_z;
    logic signed [A_W-1:0] col1_x;
    logic signed [A_W-1:0] col1_y;
    logic signed [A_W-1:0] col1_z;
    logic signed [A_W-1:0] col2_x;
    logic signed [A_W-1:0] col2_y;
    logic signed [A_W-1:0] col2_z;
  } operand_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] out0_x;
    logic signed [OUT_W-1:0] out0_y;
    logic signed [OUT_W-1:0] out0_z;
    logic signed [OUT_W-1:0] out1_x;
    logic signed [OUT_W-1:0] out1_y;
    logic signed [OUT_W-1:0] out1_z;
    logic signed [OUT_W-1:0] out2_x;
    logic signed [OUT_W-1:0] out2_y;
    logic signed [OUT_W-1:0] out2_z;
    logic                    not_rotation;
  } result_t;

  typedef struct packed {
    logic                   flag;
    logic [2:0]             neg;
    logic [2:0][NORM_W-1:0] w;
  } norm_side_t;

endpackage

### hw/rtl/rgso_front.sv
// Front end: cross product, determinant and the unnormalized second column.
// Five register stages; depends on rgso_pkg.
`timescale 1ns / 1ps
module rgso_front
  import rgso_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  operand_t              operand,
  output logic                  out_valid,
  output logic                  out_flag,
  output logic [2:0][A_W-1:0]   out_a1,
  output logic [2:0][B2_W-1:0]  out_b2,
  output logic [2:0][N_W-1:0]   out_n
);

  logic [4:0] vld;

  logic signed [A_W-1:0] a1_1 [3];
  logic signed [A_W-1:0] a2_1 [3];
  logic signed [A_W-1:0] a3_1 [3];

  logic signed [A_W-1:0] a1_2 [3];
  logic signed [A_W-1:0] a2_2 [3];
  logic signed [A_W-1:0] a3_2 [3];
  logic signed [PROD_W-1:0] pc_2 [6];
  logic signed [PROD_W-1:0] sq_2 [3];
  logic signed [PROD_W-1:0] pd_2 [3];

  logic signed [A_W-1:0] a1_3 [3];
  logic signed [A_W-1:0] a2_3 [3];
  logic signed [A_W-1:0] a3_3 [3];
  logic signed [N_W-1:0] n_3 [3];
  logic [S1_W-1:0] s1_3;
  logic signed [D12_W-1:0] d12_3;

  logic signed [A_W-1:0] a1_4 [3];
  logic signed [N_W-1:0] n_4 [3];
  logic signed [WIDE_P_W-1:0] dp_4 [3];
  logic signed [WIDE_P_W-1:0] bp_4 [3];
  logic signed [WIDE_P_W-1:0] cp_4 [3];

  logic signed [A_W-1:0] a1_5 [3];
  logic signed [N_W-1:0] n_5 [3];
  logic signed [B2_W-1:0] b2_5 [3];
  logic flag_5;

  logic signed [DET_W-1:0] det_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[3:0], in_valid};
    end
  end

  always_comb begin
    det_sum = DET_W'(dp_4[0]) + DET_W'(dp_4[1]) + DET_W'(dp_4[2]);
  end

  always_ff @(posedge clk) begin
    a1_1[0] <= operand.col0_x;
    a1_1[1] <= operand.col0_y;
    a1_1[2] <= operand.col0_z;
    a2_1[0] <= operand.col1_x;
    a2_1[1] <= operand.col1_y;
    a2_1[2] <= operand.col1_z;
    a3_1[0] <= operand.col2_x;
    a3_1[1] <= operand.col2_y;
    a3_1[2] <= operand.col2_z;

    pc_2[0] <= a1_1[1] * a2_1[2];
    pc_2[1] <= a1_1[2] * a2_1[1];
    pc_2[2] <= a1_1[2] * a2_1[0];
    pc_2[3] <= a1_1[0] * a2_1[2];
    pc_2[4] <= a1_1[0] * a2_1[1];
    pc_2[5] <= a1_1[1] * a2_1[0];
    for (int i = 0; i < 3; i++) begin
      a1_2[i] <= a1_1[i];
      a2_2[i] <= a2_1[i];
      a3_2[i] <= a3_1[i];
      sq_2[i] <= a1_1[i] * a1_1[i];
      pd_2[i] <= a1_1[i] * a2_1[i];
    end

    n_3[0] <= N_W'(pc_2[0]) - N_W'(pc_2[1]);
    n_3[1] <= N_W'(pc_2[2]) - N_W'(pc_2[3]);
    n_3[2] <= N_W'(pc_2[4]) - N_W'(pc_2[5]);
    s1_3 <= S1_W'(sq_2[0]) + S1_W'(sq_2[1]) + S1_W'(sq_2[2]);
    d12_3 <= D12_W'(pd_2[0]) + D12_W'(pd_2[1]) + D12_W'(pd_2[2]);
    for (int i = 0; i < 3; i++) begin
      a1_3[i] <= a1_2[i];
      a2_3[i] <= a2_2[i];
      a3_3[i] <= a3_2[i];
    end

    for (int i = 0; i < 3; i++) begin
      a1_4[i] <= a1_3[i];
      n_4[i] <= n_3[i];
      dp_4[i] <= a3_3[i] * n_3[i];
      bp_4[i] <= $signed({1'b0, s1_3}) * a2_3[i];
      cp_4[i] <= d12_3 * a1_3[i];
    end

    for (int i = 0; i < 3; i++) begin
      a1_5[i] <= a1_4[i];
      n_5[i] <= n_4[i];
      b2_5[i] <= B2_W'(bp_4[i]) - B2_W'(cp_4[i]);
    end
    flag_5 <= det_sum[DET_W-1] || (det_sum == '0);
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      out_a1[i] = a1_5[i];
      out_b2[i] = b2_5[i];
      out_n[i] = n_5[i];
    end
  end

  assign out_valid = vld[4];
  assign out_flag = flag_5;

endmodule

### hw/rtl/rgso_isqrt.sv
// Pipelined integer square root, one result bit per register stage.
// Carries the normalization sideband alongside; depends on rgso_pkg.
`timescale 1ns / 1ps
module rgso_isqrt
  import rgso_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [Q_W-1:0]    in_q,
  input  norm_side_t        in_side,
  output logic              out_valid,
  output logic [ROOT_W-1:0] out_root,
  output norm_side_t        out_side
);

  logic [ROOT_STEPS-1:0] vld;
  logic [Q_W-1:0] q_s [ROOT_STEPS];
  logic [Q_W-1:0] res_s [ROOT_STEPS];
  norm_side_t side_s [ROOT_STEPS];

  logic [Q_W-1:0] q_in [ROOT_STEPS];
  logic [Q_W-1:0] res_in [ROOT_STEPS];
  norm_side_t side_in [ROOT_STEPS];
  logic [Q_W-1:0] bitv [ROOT_STEPS];
  logic [Q_W-1:0] trial [ROOT_STEPS];
  logic [Q_W-1:0] q_nx [ROOT_STEPS];
  logic [Q_W-1:0] res_nx [ROOT_STEPS];

  always_comb begin
    q_in[0] = in_q;
    res_in[0] = '0;
    side_in[0] = in_side;
    for (int j = 1; j < ROOT_STEPS; j++) begin
      q_in[j] = q_s[j-1];
      res_in[j] = res_s[j-1];
      side_in[j] = side_s[j-1];
    end
    for (int j = 0; j < ROOT_STEPS; j++) begin
      bitv[j] = Q_W'(1) << (2 * (ROOT_STEPS - 1 - j));
      trial[j] = res_in[j] + bitv[j];
      if (q_in[j] >= trial[j]) begin
        q_nx[j] = q_in[j] - trial[j];
        res_nx[j] = (res_in[j] >> 1) + bitv[j];
      end else begin
        q_nx[j] = q_in[j];
        res_nx[j] = res_in[j] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[ROOT_STEPS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < ROOT_STEPS; j++) begin
      q_s[j] <= q_nx[j];
      res_s[j] <= res_nx[j];
      side_s[j] <= side_in[j];
    end
  end

  assign out_valid = vld[ROOT_STEPS-1];
  assign out_root = ROOT_W'(res_s[ROOT_STEPS-1]);
  assign out_side = side_s[ROOT_STEPS-1];

endmodule

### hw/rtl/rgso_norm3.sv
// Normalizes one 3-vector to unit length in signed fixed point.
// Shift search, squares, rgso_isqrt and a pipelined divider; uses rgso_pkg.
`timescale 1ns / 1ps
`include "rotation_gram_schmidt_orthonormalize_top_assert.svh"
module rgso_norm3
  import rgso_pkg::*;
#(
  parameter int VEC_W = 16,
  parameter int FRAC_W = 14
)(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_flag,
  input  logic [2:0][VEC_W-1:0]  in_vec,
  output logic                   out_valid,
  output logic                   out_flag,
  output logic [2:0][OUT_W-1:0]  out_vec
);

  localparam int SH_W = $clog2(VEC_W + 1);
  localparam int QUO_W = FRAC_W + 1;
  localparam int REM_W = FRAC_W + NORM_W + 1;
  localparam int CAP = (FRAC_W >= OUT_W - 1) ? (2 ** (OUT_W - 1)) - 1 : 2 ** FRAC_W;
  localparam logic [QUO_W-1:0] CAP_Q = QUO_W'(CAP);
  localparam logic [QUO_W-1:0] ONE_Q = QUO_W'(1) << FRAC_W;

  logic [5:0] vld_p;
  logic [2:0][VEC_W-1:0] mag1, mag2, mag3;
  logic [2:0] neg1, neg2, neg3, neg4, neg5;
  logic flag1, flag2, flag3, flag4, flag5;
  logic [VEC_W-1:0] m01, mx_c, mx2;
  logic [SH_W-1:0] sh_c, sh3;
  logic [2:0][NORM_W-1:0] w4, w5;
  logic [2:0][2*NORM_W-1:0] sq5;
  logic [Q_W-1:0] q6;
  norm_side_t side6;

  logic r_v;
  logic [ROOT_W-1:0] r;
  norm_side_t side_r;

  logic [QUO_W:0] vld_d;
  logic [QUO_W:0] flag_d;
  logic [2:0][REM_W-1:0] rem_d [QUO_W+1];
  logic [2:0][QUO_W-1:0] quo_d [QUO_W+1];
  logic [ROOT_W-1:0] r_d [QUO_W+1];
  logic [2:0] neg_d [QUO_W+1];
  logic [REM_W-1:0] dvs [QUO_W];
  logic [2:0][REM_W-1:0] rem_nx [QUO_W];
  logic [2:0][QUO_W-1:0] quo_nx [QUO_W];

  logic [2:0][QUO_W-1:0] cap_c;
  logic [2:0][OUT_W-1:0] mag_o;
  logic [2:0][OUT_W-1:0] res_c;

  always_comb begin
    m01 = (mag1[0] > mag1[1]) ? mag1[0] : mag1[1];
    mx_c = (m01 > mag1[2]) ? m01 : mag1[2];
    sh_c = '0;
    for (int b = 0; b < VEC_W; b++) begin
      if (mx2[b]) begin
        sh_c = SH_W'(b + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_p <= '0;
    end else begin
      vld_p <= {vld_p[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      neg1[i] <= in_vec[i][VEC_W-1];
      mag1[i] <= in_vec[i][VEC_W-1] ? (~in_vec[i] + 1'b1) : in_vec[i];
    end
    flag1 <= in_flag;

    mag2 <= mag1;
    mx2 <= mx_c;
    neg2 <= neg1;
    flag2 <= flag1;

    mag3 <= mag2;
    sh3 <= sh_c;
    neg3 <= neg2;
    flag3 <= flag2;

    for (int i = 0; i < 3; i++) begin
      w4[i] <= NORM_W'({mag3[i], {NORM_W{1'b0}}} >> sh3);
    end
    neg4 <= neg3;
    flag4 <= flag3;

    for (int i = 0; i < 3; i++) begin
      sq5[i] <= w4[i] * w4[i];
    end
    w5 <= w4;
    neg5 <= neg4;
    flag5 <= flag4;

    q6 <= Q_W'(sq5[0]) + Q_W'(sq5[1]) + Q_W'(sq5[2]);
    side6.flag <= flag5;
    side6.neg <= neg5;
    side6.w <= w5;
  end

  rgso_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vld_p[5]),
    .in_q      (q6),
    .in_side   (side6),
    .out_valid (r_v),
    .out_root  (r),
    .out_side  (side_r)
  );

  always_comb begin
    for (int j = 0; j < QUO_W; j++) begin
      dvs[j] = REM_W'(r_d[j]) << (FRAC_W - j);
      for (int i = 0; i < 3; i++) begin
        if (rem_d[j][i] >= dvs[j]) begin
          rem_nx[j][i] = rem_d[j][i] - dvs[j];
          quo_nx[j][i] = {quo_d[j][i][QUO_W-2:0], 1'b1};
        end else begin
          rem_nx[j][i] = rem_d[j][i];
          quo_nx[j][i] = {quo_d[j][i][QUO_W-2:0], 1'b0};
        end
      end
    end
    for (int i = 0; i < 3; i++) begin
      cap_c[i] = (quo_d[QUO_W][i] > CAP_Q) ? CAP_Q : quo_d[QUO_W][i];
      mag_o[i] = OUT_W'(cap_c[i]);
      res_c[i] = neg_d[QUO_W][i] ? (~mag_o[i] + 1'b1) : mag_o[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_d <= '0;
      out_valid <= 1'b0;
    end else begin
      vld_d <= {vld_d[QUO_W-1:0], r_v};
      out_valid <= vld_d[QUO_W];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      rem_d[0][i] <= REM_W'({side_r.w[i], {FRAC_W{1'b0}}}) + REM_W'(r >> 1);
    end
    quo_d[0] <= '0;
    r_d[0] <= r;
    neg_d[0] <= side_r.neg;
    flag_d[0] <= side_r.flag;
    for (int j = 0; j < QUO_W; j++) begin
      rem_d[j+1] <= rem_nx[j];
      quo_d[j+1] <= quo_nx[j];
      r_d[j+1] <= r_d[j];
      neg_d[j+1] <= neg_d[j];
      flag_d[j+1] <= flag_d[j];
    end
    out_vec <= res_c;
    out_flag <= flag_d[QUO_W];
  end

  `RGSO_ASSERT_HOLDS(a_shift_msb, vld_p[3] && !flag4, w4[0][NORM_W-1] || w4[1][NORM_W-1] || w4[2][NORM_W-1], "Normalized vector lost its leading bit.")
  `RGSO_ASSERT_HOLDS(a_root_bound, r_v, (ROOT_W'(side_r.w[0]) <= r) && (ROOT_W'(side_r.w[1]) <= r) && (ROOT_W'(side_r.w[2]) <= r), "Square root is below an entry.")
  `RGSO_ASSERT_HOLDS(a_quotient_bound, vld_d[QUO_W] && !flag_d[QUO_W], (quo_d[QUO_W][0] <= ONE_Q) && (quo_d[QUO_W][1] <= ONE_Q) && (quo_d[QUO_W][2] <= ONE_Q), "Quotient exceeds unit length.")

endmodule

### hw/rtl/rotation_gram_schmidt_orthonormalize_top.sv
// Channel    Ports                    Direction  Meaning
// command    start, busy, operand     in         one 3x3 matrix per transaction
// result     done, result             out        orthonormal columns and flag
//
// A new matrix is taken in every cycle; busy never rises.
// Pipeline: five front stages, six shift and square stages, 31 square root
// stages, and OUT_FRAC_BITS + 4 divider and output stages.
// done marks one cycle per result; the receiver cannot stall the pipeline.
// A synchronous reset clears every valid bit and drops transactions in flight.
// Depends on rgso_pkg, rgso_front and rgso_norm3.
`timescale 1ns / 1ps
`include "rotation_gram_schmidt_orthonormalize_top_assert.svh"
module rotation_gram_schmidt_orthonormalize_top
  import rgso_pkg::*;
#(
  parameter int OUT_FRAC_BITS = 14
)(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  operand_t operand,
  output logic     done,
  output result_t  result
);

  logic f_valid;
  logic f_flag;
  logic [2:0][A_W-1:0] f_a1;
  logic [2:0][B2_W-1:0] f_b2;
  logic [2:0][N_W-1:0] f_n;

  logic v0, v1, v2;
  logic g0, g1, g2;
  logic [2:0][OUT_W-1:0] u0, u1, u2;

  assign busy = 1'b0;

  rgso_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start),
    .operand   (operand),
    .out_valid (f_valid),
    .out_flag  (f_flag),
    .out_a1    (f_a1),
    .out_b2    (f_b2),
    .out_n     (f_n)
  );

  rgso_norm3 #(.VEC_W(A_W), .FRAC_W(OUT_FRAC_BITS)) u_norm0 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_flag   (f_flag),
    .in_vec    (f_a1),
    .out_valid (v0),
    .out_flag  (g0),
    .out_vec   (u0)
  );

  rgso_norm3 #(.VEC_W(B2_W), .FRAC_W(OUT_FRAC_BITS)) u_norm1 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_flag   (f_flag),
    .in_vec    (f_b2),
    .out_valid (v1),
    .out_flag  (g1),
    .out_vec   (u1)
  );

  rgso_norm3 #(.VEC_W(N_W), .FRAC_W(OUT_FRAC_BITS)) u_norm2 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_flag   (f_flag),
    .in_vec    (f_n),
    .out_valid (v2),
    .out_flag  (g2),
    .out_vec   (u2)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (g0) begin
      result <= '{not_rotation: 1'b1, default: '0};
    end else begin
      result.out0_x <= u0[0];
      result.out0_y <= u0[1];
      result.out0_z <= u0[2];
      result.out1_x <= u1[0];
      result.out1_y <= u1[1];
      result.out1_z <= u1[2];
      result.out2_x <= u2[0];
      result.out2_y <= u2[1];
      result.out2_z <= u2[2];
      result.not_rotation <= 1'b0;
    end
  end

  `RGSO_ASSERT_ALWAYS(a_lane_valid_agree, (v0 == v1) && (v0 == v2), "Normalization lanes are out of step.")
  `RGSO_ASSERT_HOLDS(a_lane_flag_agree, v0, (g0 == g1) && (g0 == g2), "Normalization lanes disagree on the flag.")
  `RGSO_ASSERT_HOLDS(a_flag_zero, done && result.not_rotation, (result.out0_x == '0) && (result.out1_y == '0) && (result.out2_z == '0), "Flagged result has nonzero entries.")

endmodule
